// ===== hw/rtl/sto_pkg.sv =====
// Shared constants, register codes and the beat type of the strided offset generator.
package sto_pkg;
	localparam int NUM_DIMS     = 4;
	localparam int DEF_MAX_DIMS = 4;
	localparam int SIZE_W       = 16;
	localparam int STRIDE_W     = 32;
	localparam int LIN_W        = 48;
	localparam int OFF_W        = 50;
	localparam int PROD_W       = SIZE_W + STRIDE_W;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SIZE_DIM0   = 3'd0,
		REG_SIZE_DIM1   = 3'd1,
		REG_SIZE_DIM2   = 3'd2,
		REG_SIZE_DIM3   = 3'd3,
		REG_STRIDE_DIM0 = 3'd4,
		REG_STRIDE_DIM1 = 3'd5,
		REG_STRIDE_DIM2 = 3'd6,
		REG_STRIDE_DIM3 = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic                             vld;
		logic                             kind;
		logic [LIN_W-1:0]                 num;
		logic [SIZE_W-1:0]                rem;
		logic [NUM_DIMS-1:0][SIZE_W-1:0]  idx;
	} beat_t;
endpackage

// ===== hw/rtl/sto_cell.sv =====
// One restoring-division step cell of the index split chain.
module sto_cell import sto_pkg::*; #(
	parameter int DIM   = NUM_DIMS - 1,
	parameter bit FINAL = 1'b0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [SIZE_W-1:0] divisor,
	input  beat_t             beat_i,
	output beat_t             beat_o
);
	logic [SIZE_W:0]   full;
	logic [SIZE_W:0]   diff;
	logic              ge;
	logic [SIZE_W-1:0] nrem;
	beat_t             nxt;
	logic              vld_q;
	beat_t             pay_q;

	always_comb begin
		full = {beat_i.rem, beat_i.num[LIN_W-1]};
		ge   = full >= {1'b0, divisor};
		diff = full - {1'b0, divisor};
		nrem = ge ? diff[SIZE_W-1:0] : full[SIZE_W-1:0];
		nxt  = beat_i;
		if (!beat_i.kind) begin
			nxt.num = {beat_i.num[LIN_W-2:0], ge};
			if (FINAL) begin
				nxt.idx[DIM] = nrem;
				nxt.rem      = '0;
			end else begin
				nxt.rem = nrem;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else vld_q <= beat_i.vld;
	end

	always_ff @(posedge clk) begin
		pay_q <= nxt;
	end

	always_comb begin
		beat_o     = pay_q;
		beat_o.vld = vld_q;
	end

`ifndef ASSERT_OFF
	a_idx_kept: assert property (@(posedge clk) disable iff (!arst_n)
		beat_i.vld && beat_i.kind |=> beat_o.idx == $past(beat_i.idx))
		else $error("index beat altered in divider cell");
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		beat_i.vld && !beat_i.kind && divisor != '0 && beat_i.rem < divisor
		|=> beat_o.rem < divisor)
		else $error("partial remainder not below divisor");
	a_num_kept: assert property (@(posedge clk) disable iff (!arst_n)
		beat_i.vld && beat_i.kind |=> beat_o.num == $past(beat_i.num))
		else $error("index beat number altered");
`endif
endmodule

// ===== hw/rtl/sto_mac.sv =====
// Bounds check, index times stride products and offset sum.
module sto_mac import sto_pkg::*; #(
	parameter int MAX_DIMS = DEF_MAX_DIMS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [NUM_DIMS-1:0][SIZE_W-1:0]   size,
	input  logic [NUM_DIMS-1:0][STRIDE_W-1:0] stride,
	input  beat_t                             beat_i,
	output logic [OFF_W-1:0]                  element_offset,
	output logic                              out_of_bounds,
	output logic                              done
);
	localparam int FIRST = NUM_DIMS - MAX_DIMS;

	logic [NUM_DIMS-1:0][SIZE_W-1:0] idx_sel;
	logic                            oob;
	logic                            vld_s1, vld_s2, vld_s3;
	logic                            oob_s1, oob_s2, oob_s3;
	logic [NUM_DIMS-1:0][PROD_W-1:0] prod_s1;
	logic [PROD_W:0]                 lo_s2, hi_s2;
	logic [OFF_W-1:0]                off_s3;

	always_comb begin
		idx_sel = beat_i.idx;
		oob     = 1'b0;
		if (!beat_i.kind) begin
			idx_sel[FIRST] = beat_i.num[SIZE_W-1:0];
			if (beat_i.num >= {{(LIN_W-SIZE_W){1'b0}}, size[FIRST]}) oob = 1'b1;
		end
		for (int d = 0; d < NUM_DIMS; d++) begin
			if (d >= FIRST) begin
				if (size[d] == '0) oob = 1'b1;
				if (beat_i.kind && beat_i.idx[d] >= size[d]) oob = 1'b1;
			end else begin
				idx_sel[d] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= beat_i.vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		oob_s1 <= oob;
		for (int d = 0; d < NUM_DIMS; d++)
			prod_s1[d] <= idx_sel[d] * stride[d];
		oob_s2 <= oob_s1;
		lo_s2  <= {1'b0, prod_s1[0]} + {1'b0, prod_s1[1]};
		hi_s2  <= {1'b0, prod_s1[2]} + {1'b0, prod_s1[3]};
		oob_s3 <= oob_s2;
		off_s3 <= oob_s2 ? '0 : ({1'b0, lo_s2} + {1'b0, hi_s2});
	end

	assign element_offset = off_s3;
	assign out_of_bounds  = oob_s3;
	assign done           = vld_s3;
endmodule

// ===== hw/rtl/strided_tensor_offset.sv =====
// Top level of the strided tensor offset generator.
// Takes one request beat per clock (busy never rises) and returns one result beat
// per request, in order, on done. A kind 0 linear number is split into indices
// by a chain of one-bit restoring divider cells, 48 per inner dimension, and every
// beat, kind 1 included, walks that chain so order holds; three more stages check
// bounds, multiply by strides and sum. Results cannot be held off.
// Write sizes and strides only while no beat is in flight.
module strided_tensor_offset import sto_pkg::*; #(
	parameter int MAX_DIMS = DEF_MAX_DIMS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  kind,
	input  logic [LIN_W-1:0]      linear_index,
	input  logic [SIZE_W-1:0]     index_dim0,
	input  logic [SIZE_W-1:0]     index_dim1,
	input  logic [SIZE_W-1:0]     index_dim2,
	input  logic [SIZE_W-1:0]     index_dim3,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic [OFF_W-1:0]      element_offset,
	output logic                  out_of_bounds,
	output logic                  done
);
	localparam int FIRST  = NUM_DIMS - MAX_DIMS;
	localparam int NDIV   = MAX_DIMS - 1;
	localparam int NCELL  = NDIV * LIN_W;

	logic [NUM_DIMS-1:0][SIZE_W-1:0]   size_q;
	logic [NUM_DIMS-1:0][STRIDE_W-1:0] stride_q;
	logic [NUM_DIMS-1:0][SIZE_W-1:0]   in_idx;
	beat_t                             chain [0:NCELL];

	// Always ready: the pipeline never stalls.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < NUM_DIMS; d++) begin
				size_q[d]   <= SIZE_W'(1);
				stride_q[d] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_SIZE_DIM0:   size_q[0]   <= cfg_data[SIZE_W-1:0];
				REG_SIZE_DIM1:   size_q[1]   <= cfg_data[SIZE_W-1:0];
				REG_SIZE_DIM2:   size_q[2]   <= cfg_data[SIZE_W-1:0];
				REG_SIZE_DIM3:   size_q[3]   <= cfg_data[SIZE_W-1:0];
				REG_STRIDE_DIM0: stride_q[0] <= cfg_data[STRIDE_W-1:0];
				REG_STRIDE_DIM1: stride_q[1] <= cfg_data[STRIDE_W-1:0];
				REG_STRIDE_DIM2: stride_q[2] <= cfg_data[STRIDE_W-1:0];
				REG_STRIDE_DIM3: stride_q[3] <= cfg_data[STRIDE_W-1:0];
				default: ;
			endcase
		end
	end

	// Build the entry beat; indices of unused leading dimensions read as zero.
	always_comb begin
		in_idx[0] = index_dim0;
		in_idx[1] = index_dim1;
		in_idx[2] = index_dim2;
		in_idx[3] = index_dim3;
		for (int d = 0; d < NUM_DIMS; d++)
			if (d < FIRST) in_idx[d] = '0;
		chain[0].vld  = start && !busy;
		chain[0].kind = kind;
		chain[0].num  = linear_index;
		chain[0].rem  = '0;
		chain[0].idx  = in_idx;
	end

	// Divider chain: innermost dimension first, one quotient bit per cell.
	for (genvar j = 0; j < NDIV; j++) begin : g_dim
		for (genvar b = 0; b < LIN_W; b++) begin : g_bit
			sto_cell #(
				.DIM   (NUM_DIMS - 1 - j),
				.FINAL (b == LIN_W - 1)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.divisor (size_q[NUM_DIMS-1-j]),
				.beat_i  (chain[j*LIN_W+b]),
				.beat_o  (chain[j*LIN_W+b+1])
			);
		end
	end

	sto_mac #(.MAX_DIMS(MAX_DIMS)) u_mac (
		.clk            (clk),
		.arst_n         (arst_n),
		.size           (size_q),
		.stride         (stride_q),
		.beat_i         (chain[NCELL]),
		.element_offset (element_offset),
		.out_of_bounds  (out_of_bounds),
		.done           (done)
	);
endmodule

// ===== sim/strided_tensor_offset_test.sv =====
// Self-checking testbench for the strided tensor offset generator.
`timescale 1ns / 1ps

module strided_tensor_offset_test;
	import sto_pkg::*;

	localparam int LATENCY    = 48 * (DEF_MAX_DIMS - 1) + 3;
	localparam int STALL_LIMIT = 5000;

	typedef enum logic {ROW_CFG, ROW_ITEM} row_op_t;

	// One directed row: either a register write or a request beat, with an
	// optional typed-in answer where it is obvious by inspection.
	typedef struct {
		row_op_t                         op;
		reg_idx_t                        reg_sel;
		logic [CFG_DATA_W-1:0]           reg_data;
		logic                            kind;
		logic [LIN_W-1:0]                lin;
		logic [NUM_DIMS-1:0][SIZE_W-1:0] idx;
		bit                              pinned;
		logic [OFF_W-1:0]                pin_off;
		logic                            pin_oob;
	} row_t;

	typedef struct packed {
		logic [OFF_W-1:0] off;
		logic             oob;
	} offset_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic                  kind = 1'b0;
	logic [LIN_W-1:0]      linear_index = '0;
	logic [SIZE_W-1:0]     index_dim0 = '0;
	logic [SIZE_W-1:0]     index_dim1 = '0;
	logic [SIZE_W-1:0]     index_dim2 = '0;
	logic [SIZE_W-1:0]     index_dim3 = '0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic [OFF_W-1:0]      element_offset;
	logic                  out_of_bounds;
	logic                  done;

	strided_tensor_offset u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.kind           (kind),
		.linear_index   (linear_index),
		.index_dim0     (index_dim0),
		.index_dim1     (index_dim1),
		.index_dim2     (index_dim2),
		.index_dim3     (index_dim3),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.element_offset (element_offset),
		.out_of_bounds  (out_of_bounds),
		.done           (done)
	);

	always #10 clk = ~clk;

	// Shadow copy of the view geometry, updated on every accepted register beat.
	logic [SIZE_W-1:0]   view_size   [NUM_DIMS];
	logic [STRIDE_W-1:0] view_stride [NUM_DIMS];

	offset_result_t pending_offsets[$];
	int             fail_count = 0;
	int             quiet_cycles = 0;

	// Handshake inputs are captured at the falling edge before the rising edge
	// that uses them, so no sampling race can arise.
	logic busy_f = 1'b1;
	logic cfg_ready_f = 1'b0;

	// Typed-in answer travelling with the beat currently being driven.
	bit               drv_pinned = 0;
	logic [OFF_W-1:0] drv_pin_off = '0;
	logic             drv_pin_oob = 1'b0;

	row_t directed_rows[$];

	// Compute where a request lands in storage for the current geometry.
	function automatic offset_result_t locate_element(logic req_kind, logic [LIN_W-1:0] lin,
			logic [NUM_DIMS-1:0][SIZE_W-1:0] idx_in);
		offset_result_t         res;
		logic [63:0]            count;
		logic [63:0]            row;
		logic [63:0]            rest;
		logic [63:0]            sum;
		logic [63:0]            pos [NUM_DIMS];
		bit                     oob;
		count = 64'd1;
		oob = 0;
		sum = '0;
		for (int d = 0; d < NUM_DIMS; d++)
			pos[d] = '0;
		if (req_kind == 1'b0) begin
			for (int d = 0; d < NUM_DIMS; d++)
				count = count * view_size[d];
			if ({16'd0, lin} >= count) begin
				oob = 1;
			end else begin
				rest = {16'd0, lin};
				for (int d = 0; d < NUM_DIMS; d++) begin
					row = 64'd1;
					for (int e = d + 1; e < NUM_DIMS; e++)
						row = row * view_size[e];
					pos[d] = rest / row;
					rest = rest % row;
				end
			end
		end else begin
			for (int d = 0; d < NUM_DIMS; d++) begin
				pos[d] = idx_in[d];
				if (idx_in[d] >= view_size[d])
					oob = 1;
			end
		end
		if (!oob) begin
			for (int d = 0; d < NUM_DIMS; d++)
				sum = sum + pos[d] * view_stride[d];
		end
		res.off = oob ? '0 : sum[OFF_W-1:0];
		res.oob = oob;
		return res;
	endfunction

	always @(negedge clk) begin
		busy_f <= busy;
		cfg_ready_f <= cfg_ready;
	end

	// Scoreboard: retire results, then record newly accepted beats and register writes.
	always @(posedge clk) begin
		offset_result_t want;
		bit             active;
		active = 0;
		if (done) begin
			active = 1;
			if (pending_offsets.size() == 0) begin
				$error("unexpected result: element_offset=%0h out_of_bounds=%0b",
					element_offset, out_of_bounds);
				fail_count++;
			end else begin
				want = pending_offsets.pop_front();
				if (element_offset !== want.off) begin
					$error("element_offset: expected %0h, got %0h", want.off, element_offset);
					fail_count++;
				end
				if (out_of_bounds !== want.oob) begin
					$error("out_of_bounds: expected %0b, got %0b", want.oob, out_of_bounds);
					fail_count++;
				end
			end
		end
		if (arst_n && start && !busy_f) begin
			active = 1;
			if (drv_pinned) begin
				want.off = drv_pin_off;
				want.oob = drv_pin_oob;
			end else begin
				want = locate_element(kind, linear_index,
					{index_dim3, index_dim2, index_dim1, index_dim0});
			end
			pending_offsets = {pending_offsets, want};
		end
		if (arst_n && cfg_valid && cfg_ready_f) begin
			active = 1;
			if (cfg_index < NUM_DIMS)
				view_size[cfg_index] = cfg_data[SIZE_W-1:0];
			else
				view_stride[cfg_index - NUM_DIMS] = cfg_data;
		end
		quiet_cycles = active ? 0 : quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("strided_tensor_offset: mismatch");
			$finish;
		end
	end

	// Write one register; call at a falling edge, returns at a falling edge
	// with valid still high so back-to-back writes never glitch it.
	task automatic write_reg(reg_idx_t sel, logic [CFG_DATA_W-1:0] value);
		logic rdy;
		cfg_valid = 1'b1;
		cfg_index = sel;
		cfg_data = value;
		do begin
			rdy = cfg_ready;
			@(posedge clk);
		end while (!rdy);
		@(negedge clk);
	endtask

	// Drain in-flight beats before touching the geometry.
	task automatic wait_idle();
		while (pending_offsets.size() != 0)
			@(negedge clk);
		@(negedge clk);
	endtask

	// Present one request beat, optionally after an idle gap; call at a falling edge.
	task automatic issue_request(logic req_kind, logic [LIN_W-1:0] lin,
			logic [NUM_DIMS-1:0][SIZE_W-1:0] idx, int idle_pct);
		logic bsy;
		if (idle_pct > 0) begin
			while ($urandom_range(99, 0) < idle_pct) begin
				start = 1'b0;
				@(negedge clk);
			end
		end
		start = 1'b1;
		kind = req_kind;
		linear_index = lin;
		index_dim0 = idx[0];
		index_dim1 = idx[1];
		index_dim2 = idx[2];
		index_dim3 = idx[3];
		do begin
			bsy = busy;
			@(posedge clk);
		end while (bsy);
		@(negedge clk);
	endtask

	task automatic add_cfg(reg_idx_t sel, logic [CFG_DATA_W-1:0] value);
		row_t r;
		r.op = ROW_CFG;
		r.reg_sel = sel;
		r.reg_data = value;
		r.kind = 1'b0;
		r.lin = '0;
		r.idx = '0;
		r.pinned = 0;
		r.pin_off = '0;
		r.pin_oob = 1'b0;
		directed_rows = {directed_rows, r};
	endtask

	task automatic add_req(logic req_kind, logic [LIN_W-1:0] lin,
			logic [NUM_DIMS-1:0][SIZE_W-1:0] idx, bit pin, logic [OFF_W-1:0] off, logic oob);
		row_t r;
		r.op = ROW_ITEM;
		r.reg_sel = REG_SIZE_DIM0;
		r.reg_data = '0;
		r.kind = req_kind;
		r.lin = lin;
		r.idx = idx;
		r.pinned = pin;
		r.pin_off = off;
		r.pin_oob = oob;
		directed_rows = {directed_rows, r};
	endtask

	// Geometry setter for a whole view: four sizes then four strides.
	task automatic load_view(logic [CFG_DATA_W-1:0] s0, logic [CFG_DATA_W-1:0] s1,
			logic [CFG_DATA_W-1:0] s2, logic [CFG_DATA_W-1:0] s3,
			logic [CFG_DATA_W-1:0] t0, logic [CFG_DATA_W-1:0] t1,
			logic [CFG_DATA_W-1:0] t2, logic [CFG_DATA_W-1:0] t3);
		add_cfg(REG_SIZE_DIM0, s0);
		add_cfg(REG_SIZE_DIM1, s1);
		add_cfg(REG_SIZE_DIM2, s2);
		add_cfg(REG_SIZE_DIM3, s3);
		add_cfg(REG_STRIDE_DIM0, t0);
		add_cfg(REG_STRIDE_DIM1, t1);
		add_cfg(REG_STRIDE_DIM2, t2);
		add_cfg(REG_STRIDE_DIM3, t3);
	endtask

	function automatic logic [SIZE_W-1:0] pick_size(int mode);
		case (mode)
			0: return SIZE_W'($urandom_range(8, 1));
			1: return 16'hFFFF;
			2: return ($urandom_range(15, 0) == 0) ? 16'd0 : SIZE_W'($urandom_range(65535, 1));
			default: return SIZE_W'($urandom_range(300, 1));
		endcase
	endfunction

	function automatic logic [STRIDE_W-1:0] pick_stride();
		case ($urandom_range(5, 0))
			0: return '0;
			1: return '1;
			2: return STRIDE_W'($urandom_range(16, 1));
			default: return $urandom();
		endcase
	endfunction

	// Random geometry: small, full-size, wide, medium or lower-rank views; upper data
	// bits of size writes carry junk that must be dropped.
	task automatic randomise_view();
		int mode;
		int rank;
		mode = $urandom_range(4, 0);
		rank = (mode == 4) ? $urandom_range(3, 1) : NUM_DIMS;
		for (int d = 0; d < NUM_DIMS; d++)
			write_reg(reg_idx_t'(REG_SIZE_DIM0 + d), {16'($urandom_range(65535, 0)),
				(d < NUM_DIMS - rank) ? 16'd1 : pick_size(mode == 4 ? 0 : mode)});
		for (int d = 0; d < NUM_DIMS; d++)
			write_reg(reg_idx_t'(REG_STRIDE_DIM0 + d), pick_stride());
		cfg_valid = 1'b0;
	endtask

	// Mostly in-range requests with random content; the rest hit the bounds or are noise.
	task automatic random_request(int idle_pct);
		logic [63:0]                     count;
		logic [63:0]                     wide;
		logic [LIN_W-1:0]                lin;
		logic [NUM_DIMS-1:0][SIZE_W-1:0] idx;
		logic                            req_kind;
		int                              pick;
		count = 64'd1;
		for (int d = 0; d < NUM_DIMS; d++)
			count = count * view_size[d];
		wide = {$urandom(), $urandom()};
		req_kind = $urandom_range(1, 0);
		pick = $urandom_range(11, 0);
		if (pick == 0 || count == 0)
			lin = wide[LIN_W-1:0];
		else if (pick == 1)
			lin = LIN_W'(count - 1);
		else if (pick == 2)
			lin = LIN_W'(count);
		else
			lin = LIN_W'(wide % count);
		for (int d = 0; d < NUM_DIMS; d++) begin
			pick = $urandom_range(11, 0);
			if (pick == 0)
				idx[d] = view_size[d];
			else if (pick == 1 || view_size[d] == 0)
				idx[d] = SIZE_W'($urandom());
			else
				idx[d] = SIZE_W'($urandom() % view_size[d]);
		end
		issue_request(req_kind, lin, idx, idle_pct);
	endtask

	initial begin
		int idle_plan [4];
		row_t r;
		idle_plan = '{0, 86, 0, 25};

		// After reset: one-element view, zero strides.
		add_req(1'b0, 48'd0, '0, 1, '0, 1'b0);
		add_req(1'b0, 48'd1, '0, 1, '0, 1'b1);
		add_req(1'b0, '1, '0, 1, '0, 1'b1);
		add_req(1'b1, '0, '0, 1, '0, 1'b0);
		add_req(1'b1, '0, {16'd1, 16'd0, 16'd0, 16'd0}, 1, '0, 1'b1);
		add_req(1'b1, '0, '1, 1, '0, 1'b1);
		// A 3x4x5x6 view with decimal strides, so offsets read as indices.
		load_view(3, 4, 5, 6, 1000, 100, 10, 1);
		add_req(1'b1, '0, {16'd5, 16'd4, 16'd3, 16'd2}, 1, 50'd2345, 1'b0);
		add_req(1'b0, 48'd359, '0, 1, 50'd2345, 1'b0);
		add_req(1'b0, 48'd360, '0, 1, '0, 1'b1);
		add_req(1'b1, '0, {16'd0, 16'd0, 16'd0, 16'd3}, 1, '0, 1'b1);
		add_req(1'b1, '0, {16'd6, 16'd0, 16'd0, 16'd0}, 1, '0, 1'b1);
		// Unused fields carry junk and must be ignored.
		add_req(1'b0, 48'd7, '1, 0, '0, 1'b0);
		add_req(1'b1, '1, {16'd1, 16'd1, 16'd1, 16'd1}, 1, 50'd1111, 1'b0);
		// Largest geometry; junk in the upper half of the size writes.
		load_view('1, '1, '1, '1, '1, '1, '1, '1);
		add_req(1'b1, '0, {4{16'hFFFE}}, 0, '0, 1'b0);
		add_req(1'b0, '1, '0, 0, '0, 1'b0);
		add_req(1'b1, '0, {16'd0, 16'd0, 16'd0, 16'hFFFF}, 1, '0, 1'b1);
		// Zero size in one dimension empties the view.
		add_cfg(REG_SIZE_DIM2, 32'hABCD_0000);
		add_req(1'b0, 48'd0, '0, 1, '0, 1'b1);
		add_req(1'b1, '0, '0, 1, '0, 1'b1);
		// Rank two: leading sizes held at 1.
		load_view(1, 1, 7, 9, 5, 5, 9, 1);
		add_req(1'b0, 48'd62, '0, 1, 50'd62, 1'b0);
		add_req(1'b1, '0, {16'd8, 16'd6, 16'd0, 16'd0}, 1, 50'd62, 1'b0);
		add_req(1'b1, '0, {16'd0, 16'd0, 16'd0, 16'd1}, 1, '0, 1'b1);

		for (int d = 0; d < NUM_DIMS; d++) begin
			view_size[d] = 16'd1;
			view_stride[d] = '0;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Walk the directed table; settle the block before each run of writes.
		foreach (directed_rows[i]) begin
			r = directed_rows[i];
			if (r.op == ROW_CFG) begin
				if (!cfg_valid) begin
					start = 1'b0;
					wait_idle();
				end
				write_reg(r.reg_sel, r.reg_data);
			end else begin
				cfg_valid = 1'b0;
				drv_pinned = r.pinned;
				drv_pin_off = r.pin_off;
				drv_pin_oob = r.pin_oob;
				issue_request(r.kind, r.lin, r.idx, 0);
			end
		end
		drv_pinned = 0;

		// Random traffic: four idling phases, fresh geometry every hundred or so beats.
		for (int ph = 0; ph < 4; ph++) begin
			for (int v = 0; v < 3; v++) begin
				start = 1'b0;
				wait_idle();
				randomise_view();
				for (int n = 0; n < 108; n++)
					random_request(idle_plan[ph]);
			end
		end
		start = 1'b0;

		while (pending_offsets.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (fail_count == 0)
			$display("strided_tensor_offset: match");
		else
			$display("strided_tensor_offset: mismatch");
		$finish;
	end

endmodule
